@@ design/alle_pkg.sv @@
// ----------------------------------------------------------------------------
// alle_pkg
// Shared types, codes and sizing for the linked list engine.
// ----------------------------------------------------------------------------
package alle_pkg;

  localparam int DefCapacity = 256;

  typedef enum logic [2:0] {
    FN_PUSH_BACK     = 3'd0,
    FN_PUSH_FRONT    = 3'd1,
    FN_POP_BACK      = 3'd2,
    FN_POP_FRONT     = 3'd3,
    FN_INSERT_AFTER  = 3'd4,
    FN_INSERT_BEFORE = 3'd5,
    FN_REMOVE_SLOT   = 3'd6,
    FN_READ_LOGICAL  = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADSLOT  = 3'd3,
    ST_BADINDEX = 3'd4
  } status_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] value;
    logic [7:0]  slot;
    logic [7:0]  logical_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  result_slot;
    logic [63:0] read_value;
    logic [7:0]  count;
  } out_item_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_INIT,    // clearing pass that builds the free list
    S_IDLE,
    S_RD,      // issue link reads for the anchor slot
    S_CHK,     // read data valid: check errors, capture neighbors
    S_WR1,
    S_WR2,
    S_WR3,
    S_WALK,    // issue a read at the current walk slot
    S_STEP,    // follow the next link or finish the walk
    S_DONE
  } state_t;

  // Controller commands to the datapath.
  typedef enum logic [3:0] {
    C_NONE,
    C_INIT,
    C_LOAD,
    C_RD,
    C_CHK,
    C_WR1,
    C_WR2,
    C_WR3,
    C_WALK_RD,
    C_WALK_STEP
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic walk_done;
    logic err;
  } stat_t;

endpackage

@@ design/alle_datapath.sv @@
// ----------------------------------------------------------------------------
// alle_datapath
// Link memories, list registers and the result register.
// ----------------------------------------------------------------------------
module alle_datapath #(
  parameter int Capacity = alle_pkg::DefCapacity
) (
  input  logic                clk,
  input  logic                rst,
  input  alle_pkg::cmd_t      cmd,
  input  alle_pkg::in_item_t  in_item,
  output alle_pkg::stat_t     stat,
  output alle_pkg::out_item_t out_item
);
  import alle_pkg::*;

  localparam int AW = (Capacity > 256) ? $clog2(Capacity) : 8;
  localparam int CW = AW;

  logic [AW-1:0] next_mem [Capacity];
  logic [AW-1:0] prev_mem [Capacity];
  logic [63:0]   val_mem  [Capacity];
  logic          occ_mem  [Capacity];

  logic [AW-1:0] head_slot, tail_slot, free_head, init_ptr;
  logic [CW-1:0] element_count;
  in_item_t      req;
  func_t         f, in_f;
  // Registered read ports.
  logic [AW-1:0] rd_next, rd_prev, fr_next;
  logic [63:0]   rd_val;
  logic          rd_occ;
  // Working values.
  logic [AW-1:0] new_slot, at_slot, left_s, right_s, frn, walk_s, walk_cnt, ra;
  status_t       st, err_code;
  logic [7:0]    rslot;
  logic [63:0]   rval;
  logic          is_ins, is_rem, ins_after;
  logic          empty, full, bad, err;

  // Write port signals (one write per memory per cycle).
  logic          wn_en, wp_en, wv_en, wo_en, wo_d;
  logic [AW-1:0] wn_a, wn_d, wp_a, wp_d, wo_a;

  assign f    = func_t'(req.func);
  assign in_f = func_t'(in_item.func);

  // Error checks once the anchor read has returned.
  assign empty = (element_count == '0);
  assign full  = (free_head == '0);
  assign bad   = (req.slot == 8'd0) || (32'(req.slot) >= 32'(Capacity)) || !rd_occ;

  always_comb begin
    err      = 1'b0;
    err_code = ST_OK;
    case (f)
      FN_PUSH_BACK, FN_PUSH_FRONT: begin
        if (full) begin
          err = 1'b1; err_code = ST_FULL;
        end
      end
      FN_POP_BACK, FN_POP_FRONT: begin
        if (empty) begin
          err = 1'b1; err_code = ST_EMPTY;
        end
      end
      FN_INSERT_AFTER, FN_INSERT_BEFORE: begin
        if (bad) begin
          err = 1'b1; err_code = ST_BADSLOT;
        end else if (full) begin
          err = 1'b1; err_code = ST_FULL;
        end
      end
      FN_REMOVE_SLOT: begin
        if (bad) begin
          err = 1'b1; err_code = ST_BADSLOT;
        end
      end
      default: begin
        if (CW'(req.logical_index) >= element_count) begin
          err = 1'b1; err_code = ST_BADINDEX;
        end
      end
    endcase
  end

  assign stat = '{init_last: (32'(init_ptr) == Capacity - 1),
                  walk_done: (walk_cnt == '0),
                  err:       err};

  // Write port mux driven by command.
  always_comb begin
    wn_en = 1'b0; wp_en = 1'b0; wv_en = 1'b0; wo_en = 1'b0; wo_d = 1'b0;
    wn_a = '0; wn_d = '0; wp_a = '0; wp_d = '0; wo_a = '0;
    case (cmd)
      C_INIT: begin
        wn_en = 1'b1; wn_a = init_ptr;
        wn_d  = (init_ptr != '0 && 32'(init_ptr) < 32'(Capacity - 1)) ?
                init_ptr + AW'(1) : '0;
        wp_en = 1'b1; wp_a = init_ptr;
        wp_d  = (init_ptr > AW'(1)) ? init_ptr - AW'(1) : '0;
        wo_en = 1'b1; wo_a = init_ptr; wo_d = 1'b0;
      end
      C_WR1: begin
        if (is_ins) begin
          // New slot links, data and occupied flag.
          wn_en = 1'b1; wn_a = new_slot; wn_d = right_s;
          wp_en = 1'b1; wp_a = new_slot; wp_d = left_s;
          wv_en = 1'b1;
          wo_en = 1'b1; wo_a = new_slot; wo_d = 1'b1;
        end else begin
          // Unlink: left.next = right; right.prev = left.
          wn_en = (left_s != '0); wn_a = left_s; wn_d = right_s;
          wp_en = (right_s != '0); wp_a = right_s; wp_d = left_s;
          wo_en = 1'b1; wo_a = at_slot; wo_d = 1'b0;
        end
      end
      C_WR2: begin
        if (is_ins) begin
          // Neighbors point at the new slot.
          wn_en = (left_s != '0); wn_a = left_s; wn_d = new_slot;
          wp_en = (right_s != '0); wp_a = right_s; wp_d = new_slot;
        end else begin
          // Freed slot goes on the free-list head.
          wn_en = 1'b1; wn_a = at_slot; wn_d = free_head;
          wp_en = (free_head != '0); wp_a = free_head; wp_d = at_slot;
        end
      end
      C_WR3: begin
        if (is_ins) begin
          wp_en = (frn != '0); wp_a = frn; wp_d = '0;
        end else begin
          wp_en = 1'b1; wp_a = at_slot; wp_d = '0;
        end
      end
      default: ;
    endcase
  end

  // Memory ports.
  assign ra = (cmd == C_WALK_RD) ? walk_s : at_slot;

  always_ff @(posedge clk) begin
    if (wn_en) next_mem[wn_a] <= wn_d;
    if (wp_en) prev_mem[wp_a] <= wp_d;
    if (wv_en) val_mem[new_slot] <= req.value;
    if (wo_en) occ_mem[wo_a] <= wo_d;
    rd_next <= next_mem[ra];
    rd_prev <= prev_mem[ra];
    rd_val  <= val_mem[ra];
    rd_occ  <= occ_mem[ra];
    fr_next <= next_mem[free_head];
  end

  // List registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_slot <= '0; tail_slot <= '0; free_head <= AW'(1);
      element_count <= '0; init_ptr <= '0;
    end else begin
      case (cmd)
        C_INIT: init_ptr <= init_ptr + AW'(1);
        C_WR1: begin
          if (is_ins) begin
            free_head <= frn;
            element_count <= element_count + CW'(1);
            if (left_s == '0) head_slot <= new_slot;
            if (right_s == '0) tail_slot <= new_slot;
          end else begin
            element_count <= element_count - CW'(1);
            if (left_s == '0) head_slot <= right_s;
            if (right_s == '0) tail_slot <= left_s;
          end
        end
        C_WR2: if (!is_ins) free_head <= at_slot;
        default: ;
      endcase
    end
  end

  // Working registers and result.
  always_ff @(posedge clk) begin
    case (cmd)
      C_LOAD: begin
        req       <= in_item;
        is_ins    <= (in_f == FN_PUSH_BACK || in_f == FN_PUSH_FRONT ||
                      in_f == FN_INSERT_AFTER || in_f == FN_INSERT_BEFORE);
        is_rem    <= (in_f == FN_POP_BACK || in_f == FN_POP_FRONT ||
                      in_f == FN_REMOVE_SLOT);
        ins_after <= (in_f == FN_PUSH_BACK || in_f == FN_INSERT_AFTER);
        case (in_f)
          FN_PUSH_BACK, FN_POP_BACK:                    at_slot <= tail_slot;
          FN_PUSH_FRONT, FN_POP_FRONT, FN_READ_LOGICAL: at_slot <= head_slot;
          default:                                      at_slot <= AW'(in_item.slot);
        endcase
        new_slot <= free_head;
        walk_s   <= head_slot;
        walk_cnt <= AW'(in_item.logical_index);
      end
      C_CHK: begin
        // Capture neighbors of the anchor and the slot after the free head.
        frn <= fr_next;
        st  <= err_code;
        if (is_ins) begin
          left_s  <= ins_after ? at_slot : rd_prev;
          right_s <= ins_after ? rd_next : at_slot;
        end else begin
          left_s  <= rd_prev;
          right_s <= rd_next;
        end
        rslot <= err ? 8'd0 : 8'(is_ins ? new_slot : at_slot);
        rval  <= (!err && is_rem) ? rd_val : 64'd0;
      end
      C_WALK_STEP: begin
        if (walk_cnt == '0) begin
          rslot <= 8'(walk_s);
          rval  <= rd_val;
        end else begin
          walk_s   <= rd_next;
          walk_cnt <= walk_cnt - AW'(1);
        end
      end
      default: ;
    endcase
  end

  assign out_item = '{status:      st,
                      result_slot: rslot,
                      read_value:  rval,
                      count:       8'(element_count)};

endmodule

@@ design/alle_ctrl.sv @@
// ----------------------------------------------------------------------------
// alle_ctrl
// Command sequencer for the linked list engine.
// ----------------------------------------------------------------------------
module alle_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  logic [2:0]      func,
  input  alle_pkg::stat_t stat,
  output alle_pkg::cmd_t  cmd
);
  import alle_pkg::*;

  state_t state, state_next;
  logic   is_walk;

  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else     state <= state_next;
  end

  // Remember whether the accepted item is a logical read.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) is_walk <= (func_t'(func) == FN_READ_LOGICAL);
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = C_NONE;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state)
      S_INIT: begin
        cmd = C_INIT;
        if (stat.init_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd = C_LOAD; state_next = S_RD;
        end
      end
      S_RD: begin
        cmd = C_RD; state_next = S_CHK;
      end
      S_CHK: begin
        cmd = C_CHK;
        if (stat.err) state_next = S_DONE;
        else if (is_walk) state_next = S_WALK;
        else state_next = S_WR1;
      end
      S_WR1: begin
        cmd = C_WR1; state_next = S_WR2;
      end
      S_WR2: begin
        cmd = C_WR2; state_next = S_WR3;
      end
      S_WR3: begin
        cmd = C_WR3; state_next = S_DONE;
      end
      S_WALK: begin
        cmd = C_WALK_RD; state_next = S_STEP;
      end
      S_STEP: begin
        cmd = C_WALK_STEP;
        if (stat.walk_done) state_next = S_DONE;
        else state_next = S_WALK;
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ design/array_linked_list_engine.sv @@
// ----------------------------------------------------------------------------
// array_linked_list_engine
// Doubly linked list of 64-bit values in a slot store with a free list.
// ----------------------------------------------------------------------------
// One command is handled at a time. After reset a clearing pass over every
// slot builds the free list before the first item is taken. An item that ends
// in an error passes through the read and check states to the done state; a
// push, pop, insert or remove adds three write states that update the link
// memories, and a logical read alternates walk and step states, following the
// next links one slot at a time from the head. The result is held while the
// output stalls, and no new item is accepted until it is taken.
module array_linked_list_engine #(
  parameter int CAPACITY = alle_pkg::DefCapacity
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  alle_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output alle_pkg::out_item_t out_item
);
  import alle_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  alle_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .func(in_item.func), .stat, .cmd
  );

  alle_datapath #(.Capacity(CAPACITY)) u_dp (
    .clk, .rst, .cmd, .in_item, .stat, .out_item
  );

endmodule

@@ tb/sv/tb_array_linked_list_engine.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_array_linked_list_engine
// Drives list commands through the engine and checks every result against a
// behavioral list model kept in the testbench, under varied idling patterns.
// ----------------------------------------------------------------------------
module tb_array_linked_list_engine;
  import alle_pkg::*;

  localparam int Cap = DefCapacity;
  localparam int CycleLimit = 5000000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  array_linked_list_engine dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .out_valid(out_valid), .out_stall(out_stall),
    .out_item(out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // List model state.
  logic [7:0]  nxt [Cap];
  logic [7:0]  prv [Cap];
  logic [63:0] vals [Cap];
  logic        used [Cap];
  logic [7:0]  head, tail, free_hd, n_elem;

  out_item_t   pending_results[$];
  int          errors = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  task automatic list_reset();
    for (int i = 0; i < Cap; i++) begin
      nxt[i] = (i > 0 && i < Cap - 1) ? 8'(i + 1) : 8'd0;
      prv[i] = (i > 1) ? 8'(i - 1) : 8'd0;
      vals[i] = '0;
      used[i] = 1'b0;
    end
    head = 0; tail = 0; free_hd = 1; n_elem = 0;
  endtask

  function automatic logic [7:0] take_slot();
    logic [7:0] s;
    s = free_hd;
    free_hd = nxt[s];
    if (free_hd != 0) prv[free_hd] = 0;
    used[s] = 1'b1;
    n_elem++;
    return s;
  endfunction

  function automatic logic [7:0] link_after(logic [63:0] v, logic [7:0] at);
    logic [7:0] s, r;
    s = take_slot();
    r = nxt[at];
    vals[s] = v; nxt[s] = r; prv[s] = at; nxt[at] = s;
    if (r != 0) prv[r] = s; else tail = s;
    return s;
  endfunction

  function automatic logic [7:0] link_before(logic [63:0] v, logic [7:0] at);
    logic [7:0] s, l;
    s = take_slot();
    l = prv[at];
    vals[s] = v; nxt[s] = at; prv[s] = l; prv[at] = s;
    if (l != 0) nxt[l] = s; else head = s;
    return s;
  endfunction

  function automatic logic [63:0] unlink(logic [7:0] s);
    logic [7:0] l, r;
    l = prv[s];
    r = nxt[s];
    if (l != 0) nxt[l] = r; else head = r;
    if (r != 0) prv[r] = l; else tail = l;
    used[s] = 1'b0;
    if (free_hd != 0) prv[free_hd] = s;
    nxt[s] = free_hd; prv[s] = 0; free_hd = s;
    n_elem--;
    return vals[s];
  endfunction

  // Works out the result of one command and updates the list model.
  function automatic out_item_t list_apply(in_item_t it);
    out_item_t o;
    logic [7:0] s;
    o = '0;
    o.status = ST_OK;
    case (func_t'(it.func))
      FN_PUSH_BACK, FN_PUSH_FRONT: begin
        if (free_hd == 0) begin
          o.status = ST_FULL;
        end else if (n_elem == 0) begin
          s = take_slot();
          nxt[s] = 0; prv[s] = 0; vals[s] = it.value; head = s; tail = s;
          o.result_slot = s;
        end else if (func_t'(it.func) == FN_PUSH_BACK) begin
          o.result_slot = link_after(it.value, tail);
        end else begin
          o.result_slot = link_before(it.value, head);
        end
      end
      FN_POP_BACK, FN_POP_FRONT: begin
        if (n_elem == 0) begin
          o.status = ST_EMPTY;
        end else begin
          s = (func_t'(it.func) == FN_POP_BACK) ? tail : head;
          o.result_slot = s;
          o.read_value = unlink(s);
        end
      end
      FN_INSERT_AFTER, FN_INSERT_BEFORE: begin
        if (it.slot == 0 || !used[it.slot]) o.status = ST_BADSLOT;
        else if (free_hd == 0) o.status = ST_FULL;
        else if (func_t'(it.func) == FN_INSERT_AFTER)
          o.result_slot = link_after(it.value, it.slot);
        else
          o.result_slot = link_before(it.value, it.slot);
      end
      FN_REMOVE_SLOT: begin
        if (it.slot == 0 || !used[it.slot]) begin
          o.status = ST_BADSLOT;
        end else begin
          o.result_slot = it.slot;
          o.read_value = unlink(it.slot);
        end
      end
      default: begin
        if (it.logical_index >= n_elem) begin
          o.status = ST_BADINDEX;
        end else begin
          s = head;
          for (int i = 0; i < it.logical_index; i++) s = nxt[s];
          o.result_slot = s;
          o.read_value = vals[s];
        end
      end
    endcase
    o.count = n_elem;
    return o;
  endfunction

  // Random 64-bit word, sometimes at an extreme.
  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly an occupied slot when there is one, else a random slot.
  function automatic logic [7:0] pick_slot();
    logic [7:0] s;
    if (n_elem != 0 && $urandom_range(0, 9) != 0) begin
      for (int k = 0; k < 64; k++) begin
        s = 8'($urandom_range(1, Cap - 1));
        if (used[s]) return s;
      end
      return head;
    end
    return 8'($urandom);
  endfunction

  // Sends one item; the prediction is made at acceptance. Valid stays high
  // after acceptance until the next item or an idle cycle replaces it.
  task automatic send_cmd(func_t f, logic [63:0] v, logic [7:0] s, logic [7:0] li);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_item <= '{func: f, value: v, slot: s, logical_index: li};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(list_apply(in_item));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Result checker.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_item);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.status !== want.status)
          $display("%0t: status exp %0d got %0d", $time, want.status, out_item.status);
        if (out_item.result_slot !== want.result_slot)
          $display("%0t: result_slot exp %0d got %0d", $time, want.result_slot,
                   out_item.result_slot);
        if (out_item.read_value !== want.read_value)
          $display("%0t: read_value exp %h got %h", $time, want.read_value,
                   out_item.read_value);
        if (out_item.count !== want.count)
          $display("%0t: count exp %0d got %0d", $time, want.count, out_item.count);
        if (out_item !== want) errors++;
      end
    end
  end

  // Receiver stalls, changed at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_array_linked_list_engine failed");
      $finish;
    end
  end

  // Directed: every command, and the empty, bad slot and bad index errors, on an empty and a short list.
  task automatic test_directed();
    send_cmd(FN_POP_BACK, '0, 0, 0);
    send_cmd(FN_POP_FRONT, '0, 0, 0);
    send_cmd(FN_READ_LOGICAL, '0, 0, 0);
    send_cmd(FN_REMOVE_SLOT, '0, 8'd1, 0);
    send_cmd(FN_INSERT_AFTER, '1, 8'd0, 0);
    send_cmd(FN_PUSH_BACK, '1, 0, 0);
    send_cmd(FN_PUSH_FRONT, '0, 0, 0);
    send_cmd(FN_INSERT_AFTER, 64'h0123_4567_89ab_cdef, 8'd1, 0);
    send_cmd(FN_INSERT_BEFORE, 64'hfedc_ba98_7654_3210, 8'd2, 0);
    send_cmd(FN_INSERT_BEFORE, '1, 8'd255, 0);
    send_cmd(FN_READ_LOGICAL, '0, 0, 8'd3);
    send_cmd(FN_READ_LOGICAL, '0, 0, 8'd4);
    send_cmd(FN_READ_LOGICAL, '0, 0, 8'd255);
    send_cmd(FN_REMOVE_SLOT, '0, 8'd3, 0);
    send_cmd(FN_POP_BACK, '0, 0, 0);
    send_cmd(FN_POP_FRONT, '0, 0, 0);
    send_cmd(FN_REMOVE_SLOT, '0, 8'd255, 0);
  endtask

  // Fill the store to full, probe full errors and the deepest read, then empty.
  task automatic test_fill_drain();
    while (free_hd != 0) send_cmd(func_t'($urandom_range(0, 1)), rand_word(), 0, 0);
    send_cmd(FN_PUSH_BACK, '1, 0, 0);
    send_cmd(FN_PUSH_FRONT, '1, 0, 0);
    send_cmd(FN_INSERT_AFTER, '1, head, 0);
    send_cmd(FN_INSERT_BEFORE, '1, tail, 0);
    send_cmd(FN_READ_LOGICAL, '0, 0, 8'd254);
    send_cmd(FN_READ_LOGICAL, '0, 0, 8'd255);
    while (n_elem != 0) send_cmd(func_t'($urandom_range(2, 3)), '0, 0, 0);
  endtask

  // Random mix, biased to grow or shrink so the list swings across its range.
  task automatic test_random(int n, int idle_pct, int st_pct);
    func_t f;
    bit grow;
    send_idle_pct = idle_pct;
    stall_pct = st_pct;
    grow = 1'b1;
    for (int k = 0; k < n; k++) begin
      if (n_elem > 200) grow = 1'b0;
      if (n_elem < 5) grow = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2: f = grow ? func_t'($urandom_range(0, 1)) : func_t'($urandom_range(2, 3));
        3, 4: f = grow ? func_t'($urandom_range(4, 5)) : FN_REMOVE_SLOT;
        5: f = func_t'($urandom_range(0, 6));
        default: f = FN_READ_LOGICAL;
      endcase
      send_cmd(f, rand_word(), pick_slot(),
               ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, n_elem)));
    end
  endtask

  initial begin
    list_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_fill_drain();
    test_random(300, 0, 0);
    drain();
    test_random(300, 80, 0);
    test_random(300, 0, 80);
    test_random(300, 13, 13);
    send_idle_pct = 0;
    stall_pct = 0;
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("tb_array_linked_list_engine passed");
    else $display("tb_array_linked_list_engine failed");
    $finish;
  end
endmodule

@@ array_linked_list_engine.f @@
design/alle_pkg.sv
design/alle_datapath.sv
design/alle_ctrl.sv
design/array_linked_list_engine.sv
tb/sv/tb_array_linked_list_engine.sv
